### rtl/rfla_pkg.sv
// Shared types and constants for the receive FIFO and line assembler.
`timescale 1ns / 1ps
package rfla_pkg;

    typedef enum logic [1:0] {
        OP_RX    = 2'd0,
        OP_POP   = 2'd1,
        OP_LINE  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_STAT,
        S_RD,
        S_EMIT
    } t_state;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7F;

    localparam logic [6:0] MAX_RES = 7'd64;

    typedef struct packed {
        logic load;
        logic exec;
        logic emit_stat;
        logic rd;
        logic emit_byte;
    } t_cmd;

    typedef struct packed {
        logic burst;
        logic last;
        logic out_free;
    } t_sts;

endpackage

### rtl/rfla_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module rfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rfla_ctrl.sv
// Controller state machine: sequences execute, status result and byte bursts.
`timescale 1ns / 1ps
module rfla_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  rfla_pkg::t_sts i_sts,
    output rfla_pkg::t_cmd o_cmd,
    output logic           o_in_ready
);
    import rfla_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_sts.burst ? S_RD : S_STAT;
            end
            S_STAT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) n_state = i_sts.last ? S_IDLE : S_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_in_ready      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_STAT: begin
                o_cmd.emit_stat = i_sts.out_free;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit_byte = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_EXEC)
        else $error("accepted item not executed next cycle");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_byte && i_sts.last) |=> r_state == S_IDLE)
        else $error("burst did not end after last byte");

endmodule

### rtl/rfla_dp.sv
// Datapath: FIFO and line storage, pointers, line editor and output register.
`timescale 1ns / 1ps
module rfla_dp #(
    parameter int FIFO_DEPTH = 256,
    parameter int LINE_DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rfla_pkg::t_cmd i_cmd,
    output rfla_pkg::t_sts o_sts,
    input  rfla_pkg::t_op  i_op,
    input  logic [7:0]     i_rx_byte,
    input  logic [6:0]     i_pop_count,
    input  logic [6:0]     i_line_max,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [7:0]     o_data_byte,
    output logic           o_valid_res,
    output logic           o_last,
    output logic [8:0]     o_fifo_level,
    output logic           o_line_ready,
    output logic [5:0]     o_line_length,
    output logic           o_dropped
);
    import rfla_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int LW = $clog2(LINE_DEPTH);
    localparam int W  = (CW > 7) ? CW : 7;
    localparam int EW = (CW > 9) ? CW : 9;

    // latched item
    t_op        r_op;
    logic [7:0] r_byte;
    logic [6:0] r_pc;
    logic [6:0] r_lm;

    // storage control
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count, n_count;
    logic [LW-1:0] r_len, n_len;
    logic          r_done, n_done;
    logic [6:0]    r_n;
    logic [6:0]    r_idx;

    // status captured at execute
    logic [8:0] r_st_level;
    logic       r_st_ready;
    logic [5:0] r_st_len;
    logic       r_st_drop;

    // output register
    logic       r_out_valid;
    logic [7:0] r_data;
    logic       r_valid_res;
    logic       r_last;
    logic [8:0] r_level;
    logic       r_ready;
    logic [5:0] r_length;
    logic       r_drop;

    logic          full;
    logic          fifo_we;
    logic          line_we;
    logic          drop;
    logic          rd_ok;
    logic [6:0]    pc_sat;
    logic [W-1:0]  cnt_w;
    logic [6:0]    n_pop;
    logic [6:0]    len7;
    logic [6:0]    lim;
    logic [6:0]    n_line;
    logic [6:0]    exec_n;
    logic [6:0]    st_len7;
    logic [EW-1:0] lvl_ext;
    logic          out_free;
    logic [7:0]    fifo_rdata;
    logic [7:0]    line_rdata;

    assign full   = (r_count == CW'(FIFO_DEPTH));
    assign pc_sat = (r_pc > MAX_RES) ? MAX_RES : r_pc;
    assign cnt_w  = W'(r_count);
    assign n_pop  = (W'(pc_sat) <= cnt_w) ? pc_sat : cnt_w[6:0];
    assign rd_ok  = (r_lm != 7'd0) && r_done;
    assign len7   = 7'(r_len);
    assign lim    = r_lm - 7'd1;
    assign n_line = rd_ok ? ((len7 < lim) ? len7 : lim) : 7'd0;

    always_comb begin
        n_wptr  = r_wptr;
        n_count = r_count;
        n_len   = r_len;
        n_done  = r_done;
        fifo_we = 1'b0;
        line_we = 1'b0;
        drop    = 1'b0;
        exec_n  = 7'd0;
        st_len7 = 7'(r_len);
        case (r_op)
            OP_RX: begin
                if (full) begin
                    drop = 1'b1;
                end else begin
                    fifo_we = 1'b1;
                    n_wptr  = (r_wptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_wptr + PW'(1);
                    n_count = r_count + CW'(1);
                end
                if (!r_done) begin
                    if (r_byte inside {CH_LF, CH_CR}) begin
                        if (r_len != '0) n_done = 1'b1;
                    end else if (r_byte inside {CH_BS, CH_DEL}) begin
                        if (r_len != '0) n_len = r_len - LW'(1);
                    end else if (r_len < LW'(LINE_DEPTH - 1)) begin
                        line_we = 1'b1;
                        n_len   = r_len + LW'(1);
                    end
                end
                st_len7 = 7'(n_len);
            end
            OP_POP: begin
                exec_n  = n_pop;
                n_count = r_count - CW'(n_pop);
            end
            OP_LINE: begin
                exec_n  = n_line;
                st_len7 = n_line;
                if (rd_ok) begin
                    n_len  = '0;
                    n_done = 1'b0;
                end
            end
            OP_CLEAR: begin
                n_wptr  = '0;
                n_count = '0;
                n_len   = '0;
                n_done  = 1'b0;
                st_len7 = 7'd0;
            end
            default: begin
                exec_n = 7'd0;
            end
        endcase
    end

    assign lvl_ext = EW'(n_count);
    assign out_free = !r_out_valid || i_out_ready;

    assign o_sts.burst    = (exec_n != 7'd0);
    assign o_sts.last     = ((r_idx + 7'd1) == r_n);
    assign o_sts.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_byte <= i_rx_byte;
            r_pc   <= i_pop_count;
            r_lm   <= i_line_max;
        end
        if (i_cmd.exec) begin
            r_st_level <= lvl_ext[8:0];
            r_st_ready <= n_done;
            r_st_len   <= st_len7[5:0];
            r_st_drop  <= drop;
        end
        if (i_cmd.emit_stat) begin
            r_data      <= 8'd0;
            r_valid_res <= 1'b0;
            r_last      <= 1'b1;
        end else if (i_cmd.emit_byte) begin
            r_data      <= (r_op == OP_POP) ? fifo_rdata : line_rdata;
            r_valid_res <= 1'b1;
            r_last      <= o_sts.last;
        end
        if (i_cmd.emit_stat || i_cmd.emit_byte) begin
            r_level  <= r_st_level;
            r_ready  <= r_st_ready;
            r_length <= r_st_len;
            r_drop   <= r_st_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_count     <= '0;
            r_len       <= '0;
            r_done      <= 1'b0;
            r_n         <= 7'd0;
            r_idx       <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_wptr  <= n_wptr;
                r_count <= n_count;
                r_len   <= n_len;
                r_done  <= n_done;
                r_n     <= exec_n;
                r_idx   <= 7'd0;
                if (r_op == OP_CLEAR) r_rptr <= '0;
            end
            if (i_cmd.emit_byte) begin
                r_idx <= r_idx + 7'd1;
                if (r_op == OP_POP) begin
                    r_rptr <= (r_rptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_rptr + PW'(1);
                end
            end
            if (i_cmd.emit_stat || i_cmd.emit_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    rfla_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && fifo_we),
        .i_waddr (r_wptr),
        .i_wdata (r_byte),
        .i_re    (i_cmd.rd && (r_op == OP_POP)),
        .i_raddr (r_rptr),
        .o_rdata (fifo_rdata)
    );

    rfla_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && line_we),
        .i_waddr (r_len),
        .i_wdata (r_byte),
        .i_re    (i_cmd.rd && (r_op == OP_LINE)),
        .i_raddr (r_idx[LW-1:0]),
        .o_rdata (line_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_data_byte   = r_data;
    assign o_valid_res   = r_valid_res;
    assign o_last        = r_last;
    assign o_fifo_level  = r_level;
    assign o_line_ready  = r_ready;
    assign o_line_length = r_length;
    assign o_dropped     = r_drop;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(FIFO_DEPTH))
        else $error("fifo count above depth");

    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_len != '0))
        else $error("pending line is empty");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd || i_cmd.emit_byte) |-> (r_idx < r_n))
        else $error("burst index beyond byte count");

endmodule

### rtl/rx_fifo_line_assembler.sv
// Top level: receive byte FIFO with line editor.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------------------------------
//  in      | i_in_valid  | o_in_ready  | i_op i_rx_byte i_pop_count i_line_max
//  out     | o_out_valid | i_out_ready | o_data_byte o_valid_res o_last o_fifo_level
//          |             |             | o_line_ready o_line_length o_dropped
//
// One item at a time: accept, an execute state, then the results.
// Status-only items go from execute to a status state; pop and line reads alternate a read
// state and an emit state per byte, for the registered read of the storage RAMs (address, then load).
// The output register lets the next item enter while the last result waits.
// Synchronous active-low reset empties both stores; no clearing pass is needed.
// A stalled output holds the burst in place until the result is taken.
`timescale 1ns / 1ps
module rx_fifo_line_assembler #(
    parameter int FIFO_DEPTH = 256,
    parameter int LINE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_rx_byte,
    input  logic [6:0] i_pop_count,
    input  logic [6:0] i_line_max,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_data_byte,
    output logic       o_valid_res,
    output logic       o_last,
    output logic [8:0] o_fifo_level,
    output logic       o_line_ready,
    output logic [5:0] o_line_length,
    output logic       o_dropped
);
    import rfla_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    rfla_dp #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (t_op'(i_op)),
        .i_rx_byte     (i_rx_byte),
        .i_pop_count   (i_pop_count),
        .i_line_max    (i_line_max),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_data_byte   (o_data_byte),
        .o_valid_res   (o_valid_res),
        .o_last        (o_last),
        .o_fifo_level  (o_fifo_level),
        .o_line_ready  (o_line_ready),
        .o_line_length (o_line_length),
        .o_dropped     (o_dropped)
    );

endmodule

### dv/tb.sv
// Testbench for rx_fifo_line_assembler: directed and random items checked against a local model.
`timescale 1ns / 1ps
module tb;
    import rfla_pkg::*;

    localparam int FIFO_N      = 256;
    localparam int LINE_N      = 64;
    localparam int TAIL_CYCLES = 16;
    localparam int LIMIT       = 1000000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       valid_res;
        logic       last;
        logic [8:0] fifo_level;
        logic       line_ready;
        logic [5:0] line_length;
        logic       dropped;
    } t_rx_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [1:0] i_op;
    logic [7:0] i_rx_byte;
    logic [6:0] i_pop_count;
    logic [6:0] i_line_max;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_data_byte;
    logic       o_valid_res;
    logic       o_last;
    logic [8:0] o_fifo_level;
    logic       o_line_ready;
    logic [5:0] o_line_length;
    logic       o_dropped;

    rx_fifo_line_assembler dut (.*);

    // model state
    logic [7:0] m_fifo [FIFO_N];
    logic [7:0] m_line [LINE_N];
    logic [7:0] m_wr;
    logic [7:0] m_rd;
    int         m_count;
    int         m_len;
    logic       m_done;

    t_rx_result due_results [$];

    int n_errors;
    int n_sent;
    int n_cycles;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        $display("[%0t] mismatch %s: got %0d want %0d", $time, what, got, want);
    endtask

    task automatic push_result(logic [7:0] data, logic valid, logic last, int len, logic drop);
        t_rx_result r;
        r.data_byte   = data;
        r.valid_res   = valid;
        r.last        = last;
        r.fifo_level  = m_count[8:0];
        r.line_ready  = m_done;
        r.line_length = len[5:0];
        r.dropped     = drop;
        due_results.push_back(r);
    endtask

    task automatic step_line_fifo(t_op op, logic [7:0] b, logic [6:0] pc, logic [6:0] lm);
        int         n;
        int         k;
        logic       drop;
        logic [7:0] got [$];
        drop = 1'b0;
        case (op)
            OP_RX: begin
                if (m_count >= FIFO_N) begin
                    drop = 1'b1;
                end else begin
                    m_fifo[m_wr] = b;
                    m_wr++;
                    m_count++;
                end
                if (!m_done) begin
                    if (b == CH_LF || b == CH_CR) begin
                        if (m_len > 0) m_done = 1'b1;
                    end else if (b == CH_BS || b == CH_DEL) begin
                        if (m_len > 0) m_len--;
                    end else if (m_len < LINE_N - 1) begin
                        m_line[m_len] = b;
                        m_len++;
                    end
                end
                push_result(8'h00, 1'b0, 1'b1, m_len, drop);
            end
            OP_POP: begin
                n = int'((pc > MAX_RES) ? MAX_RES : pc);
                if (n > m_count) n = m_count;
                for (k = 0; k < n; k++) begin
                    got.push_back(m_fifo[m_rd]);
                    m_rd++;
                    m_count--;
                end
                if (n == 0) push_result(8'h00, 1'b0, 1'b1, m_len, 1'b0);
                for (k = 0; k < n; k++)
                    push_result(got[k], 1'b1, k == n - 1, m_len, 1'b0);
            end
            OP_LINE: begin
                if (lm == 7'd0 || !m_done) begin
                    push_result(8'h00, 1'b0, 1'b1, 0, 1'b0);
                end else begin
                    n = m_len;
                    if (n >= int'(lm)) n = int'(lm) - 1;
                    m_len  = 0;
                    m_done = 1'b0;
                    if (n == 0) push_result(8'h00, 1'b0, 1'b1, 0, 1'b0);
                    for (k = 0; k < n; k++)
                        push_result(m_line[k], 1'b1, k == n - 1, n, 1'b0);
                end
            end
            default: begin
                m_wr    = '0;
                m_rd    = '0;
                m_count = 0;
                m_len   = 0;
                m_done  = 1'b0;
                push_result(8'h00, 1'b0, 1'b1, 0, 1'b0);
            end
        endcase
    endtask

    always @(posedge i_clk) begin : check_out
        t_rx_result w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result, data_byte", int'(o_data_byte), -1);
            end else begin
                w = due_results.pop_front();
                if (o_data_byte !== w.data_byte)
                    report_mismatch("data_byte", int'(o_data_byte), int'(w.data_byte));
                if (o_valid_res !== w.valid_res)
                    report_mismatch("valid_res", int'(o_valid_res), int'(w.valid_res));
                if (o_last !== w.last)
                    report_mismatch("last", int'(o_last), int'(w.last));
                if (o_fifo_level !== w.fifo_level)
                    report_mismatch("fifo_level", int'(o_fifo_level), int'(w.fifo_level));
                if (o_line_ready !== w.line_ready)
                    report_mismatch("line_ready", int'(o_line_ready), int'(w.line_ready));
                if (o_line_length !== w.line_length)
                    report_mismatch("line_length", int'(o_line_length),
                                    int'(w.line_length));
                if (o_dropped !== w.dropped)
                    report_mismatch("dropped", int'(o_dropped), int'(w.dropped));
            end
        end
    end

    // entered and left at a falling edge; valid stays high for a back-to-back item
    task automatic send_item(t_op op, logic [7:0] rx_byte, logic [6:0] pop_count,
                             logic [6:0] line_max);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_rx_byte   <= rx_byte;
        i_pop_count <= pop_count;
        i_line_max  <= line_max;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        step_line_fifo(op, rx_byte, pop_count, line_max);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(OP_POP,  8'h00, 7'd1,   7'd0);   // pop from empty fifo
        send_item(OP_LINE, 8'h00, 7'd0,   7'd64);  // read with no line pending
        send_item(OP_RX,   CH_BS, 7'd0,   7'd0);   // edits on empty line
        send_item(OP_RX,   CH_DEL, 7'd0,  7'd0);
        send_item(OP_RX,   CH_CR, 7'd0,   7'd0);   // terminator on empty line: ignored
        send_item(OP_RX,   CH_LF, 7'd0,   7'd0);
        send_item(OP_RX,   8'h41, 7'd0,   7'd0);
        send_item(OP_RX,   8'h00, 7'd0,   7'd0);
        send_item(OP_RX,   8'hFF, 7'd0,   7'd0);
        send_item(OP_RX,   CH_DEL, 7'd0,  7'd0);
        send_item(OP_RX,   8'h80, 7'd0,   7'd0);
        send_item(OP_RX,   CH_LF, 7'd0,   7'd0);
        send_item(OP_RX,   8'h78, 7'd0,   7'd0);   // editor ignores while pending
        send_item(OP_LINE, 8'h00, 7'd0,   7'd0);   // zero-size buffer: ignored
        send_item(OP_LINE, 8'h00, 7'd0,   7'd2);   // truncated to one char
        send_item(OP_RX,   8'h55, 7'd0,   7'd0);
        send_item(OP_RX,   CH_CR, 7'd0,   7'd0);
        send_item(OP_LINE, 8'h00, 7'd0,   7'd1);   // copies nothing, clears line
        send_item(OP_RX,   8'h31, 7'd0,   7'd0);
        send_item(OP_RX,   8'h32, 7'd0,   7'd0);
        send_item(OP_RX,   CH_LF, 7'd0,   7'd0);
        send_item(OP_LINE, 8'h00, 7'd0,   7'h7F);
        send_item(OP_POP,  8'h00, 7'd0,   7'd0);   // zero count
        send_item(OP_POP,  8'h00, 7'd3,   7'd0);
        send_item(OP_CLEAR, 8'hFF, 7'h7F, 7'h7F);
        wait_drained();
    endtask

    task automatic test_fill_overflow();
        int k;
        send_idle_pct  = 0;
        recv_stall_pct = 47;
        send_item(OP_CLEAR, 8'h00, 7'd0, 7'd0);
        for (k = 0; k < 70; k++)   // line saturates at 63 chars
            send_item(OP_RX, 8'($urandom_range(33, 126)), 7'($urandom_range(0, 127)),
                      7'($urandom_range(0, 127)));
        send_item(OP_RX, CH_LF, 7'd0, 7'd0);
        for (k = 0; k < 190; k++)  // fifo reaches full, last five are lost
            send_item(OP_RX, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                      7'($urandom_range(0, 127)));
        send_item(OP_LINE, 8'h00, 7'd0, 7'd64);
        send_item(OP_POP, 8'h00, 7'h7F, 7'd0);
        send_item(OP_POP, 8'h00, 7'd64, 7'd0);
        send_item(OP_POP, 8'h00, 7'd100, 7'd0);
        send_item(OP_POP, 8'h00, 7'd65, 7'd0);
        send_item(OP_POP, 8'h00, 7'd1, 7'd0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        int k;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 400;
        for (k = 0; k < 6; k++)
            send_item(OP_RX, 8'($urandom_range(0, 255)), 7'd0, 7'd0);
        send_item(OP_POP, 8'h00, 7'h7F, 7'd0);
        send_item(OP_RX, 8'h5A, 7'd0, 7'd0);
        send_item(OP_POP, 8'h00, 7'd2, 7'd0);
        wait_drained();
    endtask

    task automatic random_traffic(int target);
        int         stop_at;
        int         pick;
        int         len;
        int         k;
        logic [7:0] ch;
        logic [6:0] lm;
        stop_at = n_sent + target;
        while (n_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                // typed line with edits, then a read
                len = ($urandom_range(0, 24) == 0) ? $urandom_range(56, 70)
                                                    : $urandom_range(0, 8);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 7) == 0)
                        ch = $urandom_range(0, 1) ? CH_BS : CH_DEL;
                    else
                        ch = 8'($urandom_range(32, 126));
                    send_item(OP_RX, ch, 7'($urandom_range(0, 127)),
                              7'($urandom_range(0, 127)));
                end
                send_item(OP_RX, $urandom_range(0, 1) ? CH_CR : CH_LF,
                          7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
                case ($urandom_range(0, 7))
                    0:       lm = 7'd0;
                    1:       lm = 7'd1;
                    2:       lm = 7'($urandom_range(0, 127));
                    default: lm = 7'($urandom_range(2, len + 3));
                endcase
                send_item(OP_LINE, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                          lm);
                if ($urandom_range(0, 3) == 0)
                    send_item(OP_POP, 8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            end else if (pick < 85) begin
                send_item(t_op'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            end else if (pick < 95) begin
                send_item(OP_POP, 8'($urandom_range(0, 255)),
                          7'($urandom_range(0, 1) ? $urandom_range(0, 8)
                                                  : $urandom_range(0, 127)),
                          7'($urandom_range(0, 127)));
            end else begin
                send_item(OP_CLEAR, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                          7'($urandom_range(0, 127)));
            end
        end
    endtask

    task automatic test_random_traffic();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_traffic(30);
        send_idle_pct  = 47;
        random_traffic(30);
        send_idle_pct  = 0;
        recv_stall_pct = 47;
        random_traffic(30);
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        random_traffic(30);
        wait_drained();
    endtask

    initial begin
        n_errors       = 0;
        n_sent         = 0;
        n_cycles       = 0;
        hold_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        m_wr           = '0;
        m_rd           = '0;
        m_count        = 0;
        m_len          = 0;
        m_done         = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_op           = OP_RX;
        i_rx_byte      = 8'h00;
        i_pop_count    = 7'd0;
        i_line_max     = 7'd0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_fill_overflow();
        test_backpressure();
        test_random_traffic();

        if (due_results.size() != 0)
            report_mismatch("results missing", 0, due_results.size());
        if (n_errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
